// ===== src/kth_largest_top_k_stream_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the kth largest top-k stream block
// Shared wrappers that keep each concurrent assertion on one line.
// ---------------------------------------------------------------------------
`ifndef KTH_LARGEST_TOP_K_STREAM_TOP_MACROS_SVH
`define KTH_LARGEST_TOP_K_STREAM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KLS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KLS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define KLS_ASSERT_NEXT_ALWAYS(name, clk, ante, cons, msg) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/kls_pkg.sv =====
// ---------------------------------------------------------------------------
// Kth largest top-k stream package
// Widths, defaults and the link types passed along the chain of cells.
// ---------------------------------------------------------------------------
package kls_pkg;

   localparam int DATA_W       = 32;
   localparam int K_RANK_W     = 5;
   localparam int K_RANK_LIM   = 2 ** K_RANK_W;
   localparam int K_MAX_DEF    = 16;
   localparam logic [K_RANK_W-1:0] K_RANK_RESET = K_RANK_W'(1);

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      data_type val;
      logic     valid;
      logic     take;
   } cell_link_type;

   typedef struct packed {
      data_type val;
      logic     valid;
   } cell_next_type;

endpackage

// ===== src/kls_cell.sv =====
// ---------------------------------------------------------------------------
// Kth largest top-k stream cell
// One slot of the descending sorted store; it takes the new value, takes its
// left neighbor's value, or keeps its own.
// ---------------------------------------------------------------------------
module kls_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  clear,
   input  logic                  allow,
   input  kls_pkg::data_type     value,
   input  kls_pkg::cell_link_type prev,
   output kls_pkg::cell_link_type link,
   output kls_pkg::cell_next_type nxt
);
   import kls_pkg::*;

   data_type val_ff;
   data_type val_in;
   logic     valid_ff;
   logic     valid_in;
   logic     take;

   always_comb begin
      take = !valid_ff || (value > val_ff);
      if (!take) begin
         val_in = val_ff;
      end else if (prev.take) begin
         val_in = prev.val;
      end else begin
         val_in = value;
      end
      nxt.val   = val_in;
      nxt.valid = prev.valid && allow;
      valid_in  = clear ? 1'b0 : nxt.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (step) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         val_ff <= val_in;
      end
   end

   assign link.val   = val_ff;
   assign link.valid = valid_ff;
   assign link.take  = take;

endmodule

// ===== src/kth_largest_top_k_stream_top.sv =====
// The result of a set is registered in the output or skid buffer when its last beat is accepted.
// Throughput: one beat per cycle while the skid buffer is empty; every cell compares and shifts in the same cycle.
// The store is empty again in the cycle after a last beat, so sets follow back to back.
// A two-entry output buffer lets input continue while one result waits.
// Reset is synchronous and active high; it empties the store and sets k to one.
// ---------------------------------------------------------------------------
// Kth largest top-k stream top level
// Keeps the k largest values of a set in a chain of sorted cells and reports
// the kth largest on the last beat of each set.
// ---------------------------------------------------------------------------
module kth_largest_top_k_stream_top #(
   parameter int K_MAX = kls_pkg::K_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [kls_pkg::K_RANK_W-1:0]  csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [kls_pkg::DATA_W-1:0]    req_tdata,   // [31:0] value
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [kls_pkg::DATA_W-1:0]    rsp_tdata,   // [31:0] kth_value
   output logic [0:0]                    rsp_tuser    // [0] short_set
);
   import kls_pkg::*;

   logic [K_RANK_W-1:0] k_rank_ff;
   logic [K_RANK_W-1:0] k_rank_in;

   logic          step;
   logic          res_valid;
   data_type      res_val;
   logic          res_short;
   logic          allow [K_MAX];
   cell_link_type link  [K_MAX];
   cell_link_type prev  [K_MAX];
   cell_next_type nxt   [K_MAX];

   logic     out_valid_ff, out_valid_in;
   data_type out_val_ff, out_val_in;
   logic     out_short_ff, out_short_in;
   logic     skid_valid_ff, skid_valid_in;
   data_type skid_val_ff, skid_val_in;
   logic     skid_short_ff, skid_short_in;

   assign k_rank_in = csr_wen ? csr_wdata : k_rank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_rank_ff <= K_RANK_RESET;
      end else begin
         k_rank_ff <= k_rank_in;
      end
   end

   assign req_tready = !skid_valid_ff;
   assign step       = req_tvalid && req_tready;
   assign res_valid  = step && req_tlast;

   for (genvar g = 0; g < K_MAX; g++) begin : g_cell
      if (g < K_RANK_LIM) begin : g_lim
         assign allow[g] = (g == 0) || (K_RANK_W'(g) < k_rank_ff);
      end else begin : g_off
         assign allow[g] = 1'b0;
      end

      if (g == 0) begin : g_head
         assign prev[g] = '{val: '0, valid: 1'b1, take: 1'b0};
      end else begin : g_body
         assign prev[g] = link[g-1];
      end

      kls_cell u_cell (
         .clock (clock),
         .reset (reset),
         .step  (step),
         .clear (req_tlast),
         .allow (allow[g]),
         .value (data_type'(req_tdata)),
         .prev  (prev[g]),
         .link  (link[g]),
         .nxt   (nxt[g])
      );
   end

   always_comb begin
      logic tail;
      logic klast;
      res_val   = '0;
      res_short = 1'b0;
      for (int i = 0; i < K_MAX; i++) begin
         if (i == K_MAX - 1) begin
            tail  = nxt[i].valid;
            klast = allow[i];
         end else begin
            tail  = nxt[i].valid && !nxt[i+1].valid;
            klast = allow[i] && !allow[i+1];
         end
         res_val   = res_val | (tail ? nxt[i].val : data_type'(0));
         res_short = res_short | (klast && !nxt[i].valid);
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_val_in    = out_val_ff;
      out_short_in  = out_short_ff;
      skid_valid_in = skid_valid_ff;
      skid_val_in   = skid_val_ff;
      skid_short_in = skid_short_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_val_in    = skid_val_ff;
            out_short_in  = skid_short_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || rsp_tready) begin
            out_valid_in = 1'b1;
            out_val_in   = res_val;
            out_short_in = res_short;
         end else begin
            skid_valid_in = 1'b1;
            skid_val_in   = res_val;
            skid_short_in = res_short;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_val_ff    <= out_val_in;
      out_short_ff  <= out_short_in;
      skid_val_ff   <= skid_val_in;
      skid_short_ff <= skid_short_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_val_ff;
   assign rsp_tuser[0] = out_short_ff;

endmodule

// ===== src/kls_checker.sv =====
// ---------------------------------------------------------------------------
// Kth largest top-k stream port checker
// Watches the top level's ports for result ordering and buffer behavior.
// ---------------------------------------------------------------------------
`include "kth_largest_top_k_stream_top_macros.svh"

module kls_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          csr_wen,
   input logic [kls_pkg::K_RANK_W-1:0]  csr_wdata,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [kls_pkg::DATA_W-1:0]    req_tdata,
   input logic                          req_tlast,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [kls_pkg::DATA_W-1:0]    rsp_tdata,
   input logic [0:0]                    rsp_tuser
);

   `KLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "Stalled result beat changed.")

   `KLS_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid && req_tready, "Output not empty after reset.")

   `KLS_ASSERT_NOW(a_rise_after_last, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready && req_tlast), "Result beat without a last input beat.")

   `KLS_ASSERT_NOW(a_stall_only_full, clock, reset, !req_tready, rsp_tvalid, "Input stalled while no result is pending.")

endmodule

bind kth_largest_top_k_stream_top kls_port_checker u_kls_checker (.*);
